// File: hdl/oaids_pkg.sv
// Shared types and codes for the ordered array store.
`default_nettype none

package oaids_pkg;

    // Request codes carried in the mode field
    localparam logic [2:0] MODE_CLEAR  = 3'd0;
    localparam logic [2:0] MODE_APPEND = 3'd1;
    localparam logic [2:0] MODE_READ   = 3'd2;
    localparam logic [2:0] MODE_INSERT = 3'd3;
    localparam logic [2:0] MODE_DELETE = 3'd4;
    localparam logic [2:0] MODE_SEARCH = 3'd5;

    // Result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_BAD_POS   = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ROTATE,
        CELL_INSERT,
        CELL_DELETE
    } cell_op_t;

endpackage : oaids_pkg

`default_nettype wire

// File: hdl/ordered_array_insert_delete_search.sv
// Top level: ordered array store built as a chain of word cells plus a request sequencer.
//
//   channel   dir  beat contents (low bits first)
//   s_axis    in   mode[2:0] position[9:3] value[41:10] zero[47:42]
//   m_axis    out  status[1:0] word[33:2] found_position[40:34] count[47:41]
//
// Clear, append and insert go from the accepting edge straight to the done state,
// where the result is loaded into the output register once that is free. Read and
// delete with a valid position, and every search, first rotate the chain once around
// so each word passes cell 0, where it is compared or captured, and ends back in place.
// A new beat is accepted only while the sequencer is idle; the output register
// holds one result, so a new beat is taken while the last result waits, and a
// finished request waits in its last state until the output register frees up.
// rst_n clears the count and control; cell contents are not reset.
`default_nettype none

module ordered_array_insert_delete_search #(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // mode, position, value, zero pad
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata    // status, word, found_position, count
);
    import oaids_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > 7) ? CW : 7) + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DEL,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [2:0]           mode_reg;
    logic [6:0]           pos_reg;
    logic [WORD_BITS-1:0] val_reg;
    logic [IW-1:0]        k_reg;
    logic [CW-1:0]        count_reg;
    logic [1:0]           status_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [CW-1:0]        found_reg;
    logic                 hit_reg;

    logic                 out_valid_reg;
    logic [1:0]           out_status_reg;
    logic [31:0]          out_word_reg;
    logic [6:0]           out_found_reg;
    logic [6:0]           out_count_reg;

    // Input beat fields
    logic [2:0]           mode_in;
    logic [6:0]           pos_in;
    logic signed [31:0]   value_in;
    logic [WORD_BITS-1:0] val_kept;

    assign mode_in  = s_axis_tdata[2:0];
    assign pos_in   = s_axis_tdata[9:3];
    assign value_in = $signed(s_axis_tdata[41:10]);
    assign val_kept = WORD_BITS'(value_in);

    logic s_fire;
    logic m_fire;
    logic out_load;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_fire        = out_valid_reg && m_axis_tready;
    assign out_load      = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    // Range checks on the incoming position
    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic          full;
    logic          pos_ok;
    logic          ins_pos_ok;

    assign pos_x      = XW'(pos_in);
    assign cnt_x      = XW'(count_reg);
    assign full       = (count_reg == CW'(CAPACITY));
    assign pos_ok     = (pos_x != '0) && (pos_x <= cnt_x);
    assign ins_pos_ok = (pos_x != '0) && (pos_x <= cnt_x + 1'b1);

    // Chain of cells
    cell_op_t             cell_op;
    logic [IW-1:0]        cell_at;
    logic [WORD_BITS-1:0] chain_word [CAPACITY];

    always_comb
    begin
        cell_op = CELL_HOLD;
        cell_at = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && !full)
                begin
                    if (mode_in == MODE_APPEND)
                    begin
                        cell_op = CELL_INSERT;
                        cell_at = IW'(count_reg);
                    end
                    else if (mode_in == MODE_INSERT && ins_pos_ok)
                    begin
                        cell_op = CELL_INSERT;
                        cell_at = IW'(pos_x - 1'b1);
                    end
                end
            end
            ST_SCAN: cell_op = CELL_ROTATE;
            ST_DEL:
            begin
                cell_op = CELL_DELETE;
                cell_at = IW'(XW'(pos_reg) - 1'b1);
            end
            ST_DONE: cell_op = CELL_HOLD;
            default: cell_op = CELL_HOLD;
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_BITS-1:0] left_w;
        logic [WORD_BITS-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = val_kept;
        end
        else
        begin : g_mid_l
            assign left_w = chain_word[i-1];
        end

        // Last cell wraps to cell 0 so a full rotation restores the order
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = chain_word[0];
        end
        else
        begin : g_mid_r
            assign right_w = chain_word[i+1];
        end

        oaids_cell #(
            .IDX       (i),
            .IW        (IW),
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .clk        (clk),
            .op         (cell_op),
            .at_idx     (cell_at),
            .ins_word   (val_kept),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (chain_word[i])
        );
    end

    // Compares at the head cell during the rotation
    logic scan_hit;
    logic scan_pick;
    assign scan_hit  = (mode_reg == MODE_SEARCH) && !hit_reg
                       && (chain_word[0] == val_reg) && (XW'(k_reg) < cnt_x);
    assign scan_pick = ((mode_reg == MODE_READ) || (mode_reg == MODE_DELETE))
                       && (XW'(k_reg) + 1'b1 == XW'(pos_reg));

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_fire && !out_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        mode_reg  <= mode_in;
                        pos_reg   <= pos_in;
                        val_reg   <= val_kept;
                        word_reg  <= '0;
                        found_reg <= '0;
                        hit_reg   <= 1'b0;
                        k_reg     <= '0;
                        state_reg <= ST_DONE;
                        unique case (mode_in)
                            MODE_CLEAR:
                            begin
                                count_reg  <= '0;
                                status_reg <= STAT_OK;
                            end
                            MODE_APPEND:
                            begin
                                if (full)
                                    status_reg <= STAT_FULL;
                                else
                                begin
                                    status_reg <= STAT_OK;
                                    count_reg  <= CW'(count_reg + 1'b1);
                                end
                            end
                            MODE_READ, MODE_DELETE:
                            begin
                                if (!pos_ok)
                                    status_reg <= STAT_BAD_POS;
                                else
                                begin
                                    status_reg <= STAT_OK;
                                    state_reg  <= ST_SCAN;
                                end
                            end
                            MODE_INSERT:
                            begin
                                if (full)
                                    status_reg <= STAT_FULL;
                                else if (!ins_pos_ok)
                                    status_reg <= STAT_BAD_POS;
                                else
                                begin
                                    status_reg <= STAT_OK;
                                    count_reg  <= CW'(count_reg + 1'b1);
                                end
                            end
                            MODE_SEARCH:
                            begin
                                status_reg <= STAT_NOT_FOUND;
                                state_reg  <= ST_SCAN;
                            end
                            default: status_reg <= STAT_OK;
                        endcase
                    end
                end

                ST_SCAN:
                begin
                    k_reg <= IW'(k_reg + 1'b1);
                    if (scan_hit)
                    begin
                        hit_reg    <= 1'b1;
                        status_reg <= STAT_OK;
                        found_reg  <= CW'(k_reg) + 1'b1;
                    end
                    if (scan_pick)
                        word_reg <= chain_word[0];
                    if (k_reg == IW'(CAPACITY - 1))
                        state_reg <= (mode_reg == MODE_DELETE) ? ST_DEL : ST_DONE;
                end

                ST_DEL:
                begin
                    count_reg <= CW'(count_reg - 1'b1);
                    state_reg <= ST_DONE;
                end

                ST_DONE:
                begin
                    if (out_load)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        out_word_reg   <= 32'($unsigned(word_reg));
                        out_found_reg  <= 7'(found_reg);
                        out_count_reg  <= 7'(count_reg);
                        state_reg      <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_count_reg, out_found_reg, out_word_reg, out_status_reg};

endmodule : ordered_array_insert_delete_search

`default_nettype wire

// File: hdl/oaids_cell.sv
// One storage cell of the chain: holds a word and trades it with its neighbors.
`default_nettype none

module oaids_cell #(
    parameter int IDX       = 0,
    parameter int IW        = 6,
    parameter int WORD_BITS = 32
) (
    input  wire                       clk,
    input  oaids_pkg::cell_op_t       op,
    input  wire  [IW-1:0]             at_idx,
    input  wire  [WORD_BITS-1:0]      ins_word,
    input  wire  [WORD_BITS-1:0]      left_word,
    input  wire  [WORD_BITS-1:0]      right_word,
    output logic [WORD_BITS-1:0]      word
);
    import oaids_pkg::*;

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic                 is_at;
    logic                 is_past;

    assign is_at   = (at_idx == IW'(IDX));
    assign is_past = (IW'(IDX) > at_idx);

    // Next word: hold, take from the right (rotate or close a gap),
    // take from the left (open a gap) or load the new word
    always_comb
    begin
        word_next = word_reg;
        unique case (op)
            CELL_HOLD:   word_next = word_reg;
            CELL_ROTATE: word_next = right_word;
            CELL_INSERT:
            begin
                if (is_at)
                    word_next = ins_word;
                else if (is_past)
                    word_next = left_word;
            end
            CELL_DELETE:
            begin
                if (is_at || is_past)
                    word_next = right_word;
            end
            default:     word_next = word_reg;
        endcase
    end

    // Payload only, no reset
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule : oaids_cell

`default_nettype wire

// File: tb/ordered_array_insert_delete_search_tb.sv
// Self-checking testbench for the ordered array store: directed table, then random requests.
`default_nettype none

module ordered_array_insert_delete_search_tb;

    import oaids_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 11;
    localparam int ITEMS_PER_PHASE = 450;
    localparam int SEGMENT_ITEMS   = 60;
    localparam int HOLD_CYCLES     = 400;
    localparam int CYCLE_LIMIT     = 1_000_000;

    // Unused request codes, ignored by the block
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    // Flow-control phases
    localparam int FLOW_FREE    = 0;
    localparam int FLOW_SENDER  = 1;
    localparam int FLOW_RECEIVE = 2;
    localparam int FLOW_BOTH    = 3;

    // Request mixes for the random part
    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_EVEN  = 2;

    typedef struct packed {
        logic [2:0]  mode;
        logic [6:0]  position;
        logic [31:0] value;
    } store_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] word;
        logic [6:0]  found_position;
        logic [6:0]  count;
    } store_resp_t;

    // One row of the directed table; typed rows carry status and count, word and position zero
    typedef struct packed {
        store_req_t  req;
        logic [6:0]  reps;
        logic        typed;
        logic [1:0]  exp_status;
        logic [6:0]  exp_count;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;    // mode, position, value, zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // status, word, found_position, count

    // Shadow of the store contents
    logic [31:0] shadow_words [0:CAPACITY-1];
    int          shadow_count = 0;

    store_resp_t expected_results [$];
    plan_row_t   directed_plan [$];

    int  flow_phase = FLOW_FREE;
    bit  pressure_go = 1'b0;
    logic receiver_held = 1'b0;
    int  cycle_count = 0;
    int  mismatches = 0;
    int  accepted_items = 0;
    int  checked_results = 0;
    int  status_seen [0:3] = '{0, 0, 0, 0};
    int  peak_count = 0;

    ordered_array_insert_delete_search u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #HALF_PERIOD clk = ~clk;

    // Work out the result of one request and update the shadow store
    function automatic store_resp_t apply_request(input store_req_t req);
        store_resp_t resp;
        int pos;
        int k;
        bit hit;
        resp = '0;
        pos = int'(req.position);
        hit = 1'b0;
        case (req.mode)
            MODE_CLEAR:
                shadow_count = 0;
            MODE_APPEND:
                if (shadow_count >= CAPACITY)
                    resp.status = STAT_FULL;
                else
                begin
                    shadow_words[shadow_count] = req.value;
                    shadow_count++;
                end
            MODE_READ:
                if (pos < 1 || pos > shadow_count)
                    resp.status = STAT_BAD_POS;
                else
                    resp.word = shadow_words[pos-1];
            MODE_INSERT:
                if (shadow_count >= CAPACITY)
                    resp.status = STAT_FULL;
                else if (pos < 1 || pos > shadow_count + 1)
                    resp.status = STAT_BAD_POS;
                else
                begin
                    for (k = shadow_count; k > pos - 1; k--)
                        shadow_words[k] = shadow_words[k-1];
                    shadow_words[pos-1] = req.value;
                    shadow_count++;
                end
            MODE_DELETE:
                if (pos < 1 || pos > shadow_count)
                    resp.status = STAT_BAD_POS;
                else
                begin
                    resp.word = shadow_words[pos-1];
                    for (k = pos - 1; k + 1 < shadow_count; k++)
                        shadow_words[k] = shadow_words[k+1];
                    shadow_count--;
                end
            MODE_SEARCH:
            begin
                resp.status = STAT_NOT_FOUND;
                for (k = 0; k < shadow_count; k++)
                begin
                    if (!hit && shadow_words[k] == req.value)
                    begin
                        hit = 1'b1;
                        resp.status = STAT_OK;
                        resp.found_position = 7'(k + 1);
                    end
                end
            end
            default:
                ;
        endcase
        resp.count = 7'(shadow_count);
        return resp;
    endfunction

    function automatic bit sender_idles();
        case (flow_phase)
            FLOW_SENDER: return $urandom_range(0, 99) < 67;
            FLOW_BOTH:   return $urandom_range(0, 99) < 36;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (flow_phase)
            FLOW_RECEIVE: return $urandom_range(0, 99) < 67;
            FLOW_BOTH:    return $urandom_range(0, 99) < 36;
            default:      return 1'b0;
        endcase
    endfunction

    // Words: often one already stored, so searches hit and duplicates occur
    function automatic logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll <= 3 && shadow_count > 0)
            return shadow_words[$urandom_range(0, shadow_count - 1)];
        if (roll <= 5)
            return 32'($signed($urandom_range(0, 7)) - 4);
        if (roll == 6)
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        return $urandom;
    endfunction

    // Positions: mostly inside the legal range, sometimes anywhere in the field
    function automatic logic [6:0] pick_position(input logic [2:0] mode);
        if ($urandom_range(0, 99) < 15)
            return 7'($urandom_range(0, 127));
        if (mode == MODE_INSERT)
            return 7'($urandom_range(1, shadow_count + 1));
        if (shadow_count == 0)
            return 7'($urandom_range(0, 2));
        return 7'($urandom_range(1, shadow_count));
    endfunction

    function automatic logic [2:0] pick_mode(input int mix);
        int roll;
        roll = $urandom_range(0, 199);
        if (roll == 0)
            return MODE_CLEAR;
        if (roll == 1)
            return MODE_SPARE6;
        if (roll == 2)
            return MODE_SPARE7;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
                if (roll < 36)      return MODE_APPEND;
                else if (roll < 72) return MODE_INSERT;
                else if (roll < 82) return MODE_READ;
                else if (roll < 92) return MODE_SEARCH;
                else                return MODE_DELETE;
            MIX_DRAIN:
                if (roll < 45)      return MODE_DELETE;
                else if (roll < 60) return MODE_READ;
                else if (roll < 76) return MODE_SEARCH;
                else if (roll < 88) return MODE_APPEND;
                else                return MODE_INSERT;
            default:
                if (roll < 20)      return MODE_APPEND;
                else if (roll < 40) return MODE_INSERT;
                else if (roll < 65) return MODE_DELETE;
                else if (roll < 82) return MODE_READ;
                else                return MODE_SEARCH;
        endcase
    endfunction

    task automatic plan_row(input logic [2:0] mode, input int pos, input logic [31:0] value,
                            input int reps, input bit typed, input logic [1:0] status,
                            input int count);
        plan_row_t row;
        row.req        = '{mode: mode, position: 7'(pos), value: value};
        row.reps       = 7'(reps);
        row.typed      = typed;
        row.exp_status = status;
        row.exp_count  = 7'(count);
        directed_plan.push_back(row);
    endtask

    // Offer one beat, wait for the handshake, then queue what it should produce
    task automatic send_request(input store_req_t req, input bit typed, input store_resp_t typed_resp);
        store_resp_t predicted;
        @(negedge clk);
        while (sender_idles())
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, req.value, req.position, req.mode};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = apply_request(req);
        accepted_items++;
        if (shadow_count > peak_count)
            peak_count = shadow_count;
        expected_results.push_back(typed ? typed_resp : predicted);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h (cycle %0d)", field, got, want, cycle_count);
        mismatches++;
    endtask

    // Receiver ready, held low during the long hold-off
    always @(negedge clk)
        m_axis_tready <= !receiver_held && !receiver_stalls();

    initial
    begin
        wait (pressure_go);
        @(negedge clk);
        receiver_held <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        receiver_held <= 1'b0;
    end

    // Result checker
    always @(posedge clk)
    begin
        store_resp_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected beat", m_axis_tdata[31:0], 32'd0);
            else
            begin
                want = expected_results.pop_front();
                checked_results++;
                status_seen[m_axis_tdata[1:0]]++;
                if (m_axis_tdata[1:0] != want.status)
                    report_mismatch("status", 32'(m_axis_tdata[1:0]), 32'(want.status));
                if (m_axis_tdata[33:2] != want.word)
                    report_mismatch("word", m_axis_tdata[33:2], want.word);
                if (m_axis_tdata[40:34] != want.found_position)
                    report_mismatch("found_position", 32'(m_axis_tdata[40:34]),
                                    32'(want.found_position));
                if (m_axis_tdata[47:41] != want.count)
                    report_mismatch("count", 32'(m_axis_tdata[47:41]), 32'(want.count));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        plan_row_t   row;
        store_req_t  req;
        store_resp_t typed_resp;
        int mix;
        int n;
        int r;

        // Empty store: every position refused, spare modes ignored
        plan_row(MODE_READ,   1,   32'd0,          1, 1, STAT_BAD_POS,   0);
        plan_row(MODE_DELETE, 0,   32'd0,          1, 1, STAT_BAD_POS,   0);
        plan_row(MODE_SEARCH, 0,   32'd0,          1, 1, STAT_NOT_FOUND, 0);
        plan_row(MODE_INSERT, 2,   32'd5,          1, 1, STAT_BAD_POS,   0);
        plan_row(MODE_SPARE6, 0,   32'd0,          1, 1, STAT_OK,        0);
        plan_row(MODE_SPARE7, 127, 32'hffff_ffff,  1, 1, STAT_OK,        0);
        // Extreme words, insert at front and at count+1
        plan_row(MODE_APPEND, 0,   32'h7fff_ffff,  1, 1, STAT_OK,        1);
        plan_row(MODE_APPEND, 0,   32'h8000_0000,  1, 1, STAT_OK,        2);
        plan_row(MODE_INSERT, 1,   32'hffff_ffff,  1, 1, STAT_OK,        3);
        plan_row(MODE_INSERT, 4,   32'd0,          1, 1, STAT_OK,        4);
        plan_row(MODE_READ,   1,   32'd0,          1, 0, STAT_OK,        0);
        plan_row(MODE_READ,   4,   32'd0,          1, 0, STAT_OK,        0);
        plan_row(MODE_READ,   127, 32'd0,          1, 1, STAT_BAD_POS,   4);
        plan_row(MODE_DELETE, 5,   32'd0,          1, 1, STAT_BAD_POS,   4);
        plan_row(MODE_SEARCH, 0,   32'h8000_0000,  1, 0, STAT_OK,        0);
        plan_row(MODE_SEARCH, 0,   32'd12345,      1, 1, STAT_NOT_FOUND, 4);
        plan_row(MODE_DELETE, 1,   32'd0,          1, 0, STAT_OK,        0);
        plan_row(MODE_DELETE, 3,   32'd0,          1, 0, STAT_OK,        0);
        plan_row(MODE_CLEAR,  0,   32'd0,          1, 1, STAT_OK,        0);
        plan_row(MODE_INSERT, 0,   32'd9,          1, 1, STAT_BAD_POS,   0);
        // Fill to capacity, then full store refuses before looking at position
        plan_row(MODE_APPEND, 0,   32'd100,       64, 0, STAT_OK,        0);
        plan_row(MODE_APPEND, 0,   32'd1,          1, 1, STAT_FULL,     64);
        plan_row(MODE_INSERT, 0,   32'd1,          1, 1, STAT_FULL,     64);
        plan_row(MODE_READ,   64,  32'd0,          1, 0, STAT_OK,        0);
        plan_row(MODE_SEARCH, 0,   32'd163,        1, 0, STAT_OK,        0);
        plan_row(MODE_DELETE, 64,  32'd0,          1, 0, STAT_OK,        0);
        plan_row(MODE_INSERT, 64,  32'h5a5a_a5a5,  1, 0, STAT_OK,        0);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table
        foreach (directed_plan[i])
        begin
            row = directed_plan[i];
            typed_resp = '{status: row.exp_status, word: 32'd0, found_position: 7'd0,
                           count: row.exp_count};
            for (r = 0; r < int'(row.reps); r++)
            begin
                req = row.req;
                req.value = row.req.value + 32'(r);
                send_request(req, row.typed, typed_resp);
            end
        end

        // Random requests, one flow-control phase after another
        for (int phase = FLOW_FREE; phase <= FLOW_BOTH; phase++)
        begin
            flow_phase = phase;
            if (phase == FLOW_FREE)
                pressure_go = 1'b1;
            mix = MIX_EVEN;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % SEGMENT_ITEMS == 0)
                begin
                    r = $urandom_range(0, 99);
                    mix = (r < 45) ? MIX_FILL : (r < 75) ? MIX_EVEN : MIX_DRAIN;
                end
                req.mode     = pick_mode(mix);
                req.position = pick_position(req.mode);
                req.value    = pick_value();
                send_request(req, 1'b0, '0);
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        flow_phase = FLOW_FREE;

        // Drain, then watch for stray beats
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (CAPACITY + 8) @(posedge clk);

        $display("covered %0d requests, %0d results checked, peak fill %0d of %0d",
                 accepted_items, checked_results, peak_count, CAPACITY);
        $display("status mix: ok %0d, full %0d, bad position %0d, not found %0d",
                 status_seen[STAT_OK], status_seen[STAT_FULL],
                 status_seen[STAT_BAD_POS], status_seen[STAT_NOT_FOUND]);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule : ordered_array_insert_delete_search_tb

`default_nettype wire

// File: files.f
hdl/oaids_pkg.sv
hdl/oaids_cell.sv
hdl/ordered_array_insert_delete_search.sv
tb/ordered_array_insert_delete_search_tb.sv
